// File: rtl/core/lsbx_pkg.sv
`timescale 1ns / 1ps

package lsbx_pkg;

  localparam int MODE_W = 2;
  localparam int BYTE_W = 8;
  localparam int CNT_W = 4;
  localparam int COUNT_W = 24;
  localparam int PHASE_W = 2;
  localparam int PATTERN_COUNT = 4;
  localparam int PAT_W = $clog2(PATTERN_COUNT);
  localparam int HEADER_BYTES_DEF = 32;

  localparam logic [MODE_W-1:0] MODE_LSB1 = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LSB4 = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LSBI = 2'd2;

  // color phases after the header, phase for red is skipped
  localparam logic [PHASE_W-1:0] PHASE_FIRST = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_RED = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_LAST = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] carrier_byte;
    logic              last_carrier;
  } carrier_t;

endpackage

// File: rtl/core/lsbx_input_reg.sv
`timescale 1ns / 1ps

module lsbx_input_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  lsbx_pkg::carrier_t in_item,
  output logic               item_valid,
  output lsbx_pkg::carrier_t item,
  input  logic               take
);
  import lsbx_pkg::*;

  logic load;

  assign in_stall = item_valid && !take;
  assign load = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= in_item;
    end
  end

endmodule

// File: rtl/core/lsbx_extract.sv
`timescale 1ns / 1ps

module lsbx_extract #(
  parameter int HEADER_BYTES = lsbx_pkg::HEADER_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic [lsbx_pkg::MODE_W-1:0]  cfg_data,
  input  logic                         item_valid,
  input  lsbx_pkg::carrier_t           item,
  output logic                         take,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lsbx_pkg::BYTE_W-1:0]  hidden_byte,
  output logic [lsbx_pkg::COUNT_W-1:0] byte_number
);
  import lsbx_pkg::*;

  localparam int HPOS_W = $clog2(HEADER_BYTES + 1);

  logic [MODE_W-1:0]        lsb_mode;
  logic [BYTE_W-1:0]        bit_accumulator;
  logic [CNT_W-1:0]         bits_collected;
  logic [PATTERN_COUNT-1:0] pattern_flags;
  logic [HPOS_W-1:0]        header_position;
  logic [PHASE_W-1:0]       color_phase;
  logic [COUNT_W-1:0]       hidden_count;

  logic [BYTE_W-1:0]        bit_accumulator_next;
  logic [CNT_W-1:0]         bits_collected_next;
  logic [PATTERN_COUNT-1:0] pattern_flags_next;
  logic [HPOS_W-1:0]        header_position_next;
  logic [PHASE_W-1:0]       color_phase_next;
  logic [COUNT_W-1:0]       hidden_count_next;

  logic              fire;
  logic              emit;
  logic              collect1;
  logic              collect4;
  logic              lsbi_bit;
  logic [BYTE_W-1:0] acc_shift;
  logic [CNT_W-1:0]  cnt_sum;
  logic [BYTE_W-1:0] cbyte;

  assign take = !out_valid || !out_stall;
  assign fire = item_valid && take;
  assign cbyte = item.carrier_byte;

  always_comb begin
    collect1 = 1'b0;
    collect4 = 1'b0;
    lsbi_bit = cbyte[0] ^ pattern_flags[cbyte[PAT_W:1]];
    pattern_flags_next = pattern_flags;
    header_position_next = header_position;
    color_phase_next = color_phase;
    case (lsb_mode)
      MODE_LSB4: begin
        collect4 = 1'b1;
      end
      MODE_LSBI: begin
        if (header_position < HPOS_W'(HEADER_BYTES)) begin
          if (header_position < HPOS_W'(PATTERN_COUNT)) begin
            pattern_flags_next[header_position[PAT_W-1:0]] = cbyte[0];
          end
          header_position_next = header_position + HPOS_W'(1);
        end else begin
          color_phase_next = (color_phase == PHASE_LAST) ? PHASE_FIRST
                                                         : color_phase + PHASE_W'(1);
          collect1 = (color_phase != PHASE_RED);
        end
      end
      default: begin
        collect1 = 1'b1;
      end
    endcase
  end

  // shift the new bits in; a full byte leaves and clears the accumulator
  always_comb begin
    acc_shift = bit_accumulator;
    cnt_sum = bits_collected;
    if (collect4) begin
      acc_shift = {bit_accumulator[3:0], cbyte[3:0]};
      cnt_sum = bits_collected + CNT_W'(4);
    end else if (collect1) begin
      acc_shift = {bit_accumulator[BYTE_W-2:0],
                   (lsb_mode == MODE_LSBI) ? lsbi_bit : cbyte[0]};
      cnt_sum = bits_collected + CNT_W'(1);
    end
    emit = cnt_sum[CNT_W-1];
    bit_accumulator_next = emit ? '0 : acc_shift;
    bits_collected_next = emit ? '0 : cnt_sum;
    hidden_count_next = emit ? hidden_count + COUNT_W'(1) : hidden_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lsb_mode <= MODE_LSB1;
      bit_accumulator <= '0;
      bits_collected <= '0;
      pattern_flags <= '0;
      header_position <= '0;
      color_phase <= PHASE_FIRST;
      hidden_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        lsb_mode <= cfg_data;
      end
      if (take) begin
        out_valid <= fire && emit;
      end
      if (fire) begin
        if (item.last_carrier) begin
          bit_accumulator <= '0;
          bits_collected <= '0;
          pattern_flags <= '0;
          header_position <= '0;
          color_phase <= PHASE_FIRST;
          hidden_count <= '0;
        end else begin
          bit_accumulator <= bit_accumulator_next;
          bits_collected <= bits_collected_next;
          pattern_flags <= pattern_flags_next;
          header_position <= header_position_next;
          color_phase <= color_phase_next;
          hidden_count <= hidden_count_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      hidden_byte <= acc_shift;
      byte_number <= hidden_count;
    end
  end

`ifndef NO_ASSERTIONS
  a_count_below_byte: assert property (@(posedge clk) disable iff (rst)
    bits_collected < CNT_W'(8))
    else $error("partial bit count reached a full byte");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    color_phase != 2'd3)
    else $error("color phase out of range");

  a_header_range: assert property (@(posedge clk) disable iff (rst)
    header_position <= HPOS_W'(HEADER_BYTES))
    else $error("header position past header");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    fire && item.last_carrier |=> bits_collected == '0 && hidden_count == '0
      && header_position == '0)
    else $error("end of image did not restart the extractor");

  a_number_steps: assert property (@(posedge clk) disable iff (rst)
    fire && emit && !item.last_carrier |=> hidden_count == byte_number + COUNT_W'(1))
    else $error("byte counter did not advance with a result");
`endif

endmodule

// File: rtl/core/lsb_stego_bit_extractor_unit.sv
`timescale 1ns / 1ps

// lsb steganography bit extractor
// carrier bytes (BGR order) enter on carrier_byte/last_carrier with in_valid;
// the block raises in_stall to hold them off. each transaction is taken at a
// clock edge with in_valid high and in_stall low.
// reassembled hidden bytes leave on hidden_byte/byte_number with out_valid;
// the receiver raises out_stall to hold a result, which then stays unchanged.
// lsb_mode (0 lsb1, 1 lsb4, 2 lsbi with header flags and red skip) comes on
// the cfg channel (cfg_valid/cfg_ready, cfg_data); the user writes it only
// while the block is idle, which the block does not enforce. a carrier byte
// lands in the input register at accept; the result register loads from it
// unless a stalled result holds it. one carrier byte per cycle while no result
// is stalled, via the combinational step logic; at most one result per byte.
// a stalled receiver holds the result register, which in turn holds the input
// register and raises in_stall; a byte that yields no result still waits.
// reset clears all extraction state, the byte counter and lsb_mode (lsb1).
// last_carrier restarts the extraction after its byte, keeping lsb_mode;
// a pending partial byte is dropped. byte_number wraps at 2^24.
module lsb_stego_bit_extractor_unit #(
  parameter int HEADER_BYTES = lsbx_pkg::HEADER_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lsbx_pkg::BYTE_W-1:0]  carrier_byte,
  input  logic                         last_carrier,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lsbx_pkg::BYTE_W-1:0]  hidden_byte,
  output logic [lsbx_pkg::COUNT_W-1:0] byte_number,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lsbx_pkg::MODE_W-1:0]  cfg_data
);
  import lsbx_pkg::*;

  carrier_t in_item;
  carrier_t item;
  logic     item_valid;
  logic     take;

  assign in_item.carrier_byte = carrier_byte;
  assign in_item.last_carrier = last_carrier;
  assign cfg_ready = 1'b1;

  lsbx_input_reg u_input_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .take       (take)
  );

  lsbx_extract #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_extract (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .item_valid  (item_valid),
    .item        (item),
    .take        (take),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hidden_byte (hidden_byte),
    .byte_number (byte_number)
  );

endmodule
